// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the scheduler; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, disabled while reset is low
`define RRTS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion, also checked during reset
`define RRTS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("assertion failed");

`else

`define RRTS_ASSERT(name, clk, rst_n, prop)
`define RRTS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared sizes, opcodes and the result beat type of the thread scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    // number of thread slots and derived index widths
    localparam int SLOTS   = 4;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CW = SLOT_W + 1;

    // counter and opcode widths
    localparam int TICK_W  = 8;
    localparam int TIME_W  = 8;
    localparam int DELAY_W = 8;
    localparam int OP_W    = 3;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_YIELD     = 3'd1,
        OP_CREATE    = 3'd2,
        OP_EXIT      = 3'd3,
        OP_SET_DELAY = 3'd4
    } t_opcode;

    // one result beat
    typedef struct packed {
        logic [SLOT_W-1:0]  current_slot;
        logic [SLOT_W-1:0]  new_slot;
        logic               create_failed;
        logic [SLOTS-1:0]   live_mask;
        logic [TIME_W-1:0]  time_now;
        logic [DELAY_W-1:0] current_delay;
        logic               halted;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/round_robin_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_unit
// Four-slot round-robin thread scheduler with delay counters and time base.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel (i_in_valid / o_in_ready) carries an opcode and a delay
//   value: tick, yield, create, exit or set_delay. Each event beat yields
//   exactly one result beat on the result channel (o_out_valid /
//   i_out_ready) showing the running slot, claimed slot, create failure,
//   live mask, time count, running slot's delay and halt flag.
//   The config channel (i_cfg_valid / o_cfg_ready) writes ticks_per_unit;
//   it is always ready and should be written while the block is idle.
// Result path and throughput:
//   Results are registered in the result register, or the skid on a stall.
//   One event per cycle is taken while the skid is empty; the slot pick,
//   prescaler and delay update settle combinationally ahead of the register.
// Reset:
//   Synchronous, active low: slot 0 live and running, counters cleared,
//   ticks_per_unit = 1, no result pending.
// Stall:
//   A two-entry output buffer (result register plus skid) lets one more
//   event in while a result waits; with both full o_in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module round_robin_thread_scheduler_unit
    import rrts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [TICK_W-1:0]  i_cfg_data,
    // event channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [DELAY_W-1:0] i_delay_value,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [SLOT_W-1:0]       o_current_slot,
    output logic [SLOT_W-1:0]       o_new_slot,
    output logic                    o_create_failed,
    output logic [SLOTS-1:0]        o_live_mask,
    output logic [TIME_W-1:0]       o_time_now,
    output logic [DELAY_W-1:0]      o_current_delay,
    output logic                    o_halted
);

    logic    in_acc;
    logic    out_take;
    t_result core_res;

    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_skd, n_skd;
    logic    r_skd_valid, n_skd_valid;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skd_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;

    // scheduler state and update
    rrts_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_step        (in_acc),
        .i_opcode      (i_opcode),
        .i_delay_value (i_delay_value),
        .o_result      (core_res)
    );

    // result register and skid stage
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_skd       = r_skd;
        n_skd_valid = r_skd_valid;
        if (out_take || !r_out_valid) begin
            if (r_skd_valid) begin
                n_out       = r_skd;
                n_out_valid = 1'b1;
                n_skd_valid = 1'b0;
            end else if (in_acc) begin
                n_out       = core_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_acc) begin
            n_skd       = core_res;
            n_skd_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    // result ports
    assign o_out_valid     = r_out_valid;
    assign o_current_slot  = r_out.current_slot;
    assign o_new_slot      = r_out.new_slot;
    assign o_create_failed = r_out.create_failed;
    assign o_live_mask     = r_out.live_mask;
    assign o_time_now      = r_out.time_now;
    assign o_current_delay = r_out.current_delay;
    assign o_halted        = r_out.halted;

    // skid only fills behind a pending result
    `RRTS_ASSERT(a_skd_behind, i_clk, i_rst_n, r_skd_valid |-> r_out_valid)
    // an event taken during a stall lands in the skid stage
    `RRTS_ASSERT(a_skd_fill, i_clk, i_rst_n, (in_acc && r_out_valid && !i_out_ready) |=> r_skd_valid)
    // a pending result only goes away when it was taken
    `RRTS_ASSERT(a_out_drop, i_clk, i_rst_n, $fell(r_out_valid) |-> $past(i_out_ready))

endmodule

`default_nettype wire

// File: hdl/rrts_core.sv
// ----------------------------------------------------------------------------
// rrts_core
// Scheduler state and its update for each accepted event beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rrts_core
    import rrts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr,
    input  wire logic [TICK_W-1:0]  i_cfg_data,
    input  wire logic               i_step,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [DELAY_W-1:0] i_delay_value,
    output t_result                 o_result
);

    // state registers
    logic [TICK_W-1:0]  r_tpu;
    logic [SLOTS-1:0]   r_live,  n_live;
    logic [SLOT_W-1:0]  r_run,   n_run;
    logic [TICK_W-1:0]  r_presc, n_presc;
    logic [TIME_W-1:0]  r_units, n_units;
    logic [DELAY_W-1:0] r_delay [SLOTS];
    logic [DELAY_W-1:0] n_delay [SLOTS];
    logic               r_halt,  n_halt;

    // helper terms
    logic [SLOT_CW-1:0] rot_idx;
    logic [SLOT_W-1:0]  rot_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic               free_found;
    logic [SLOTS-1:0]   exit_live;
    logic [SLOT_W-1:0]  first_live;
    logic [TICK_W-1:0]  unit_len;
    logic [TICK_W:0]    presc_inc;
    logic               wrap;
    logic [SLOT_W-1:0]  new_slot;
    logic               failed;

    // next live slot after the running one, nearest wins
    always_comb begin
        rot_slot = r_run;
        rot_idx  = '0;
        for (int k = SLOTS - 1; k >= 1; k--) begin
            rot_idx = {1'b0, r_run} + SLOT_CW'(k);
            if (rot_idx >= SLOT_CW'(SLOTS)) begin
                rot_idx = rot_idx - SLOT_CW'(SLOTS);
            end
            if (r_live[rot_idx[SLOT_W-1:0]]) begin
                rot_slot = rot_idx[SLOT_W-1:0];
            end
        end
    end

    // lowest free slot, and lowest live slot once the running one leaves
    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        first_live = r_run;
        exit_live  = r_live;
        exit_live[r_run] = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                free_slot  = SLOT_W'(i);
                free_found = 1'b1;
            end
            if (exit_live[i]) begin
                first_live = SLOT_W'(i);
            end
        end
    end

    // prescaler wrap, a zero unit length counts as one
    always_comb begin
        unit_len  = (r_tpu == '0) ? TICK_W'(1) : r_tpu;
        presc_inc = {1'b0, r_presc} + (TICK_W+1)'(1);
        wrap      = presc_inc >= {1'b0, unit_len};
    end

    // event decode and next state
    always_comb begin
        n_live   = r_live;
        n_run    = r_run;
        n_presc  = r_presc;
        n_units  = r_units;
        n_delay  = r_delay;
        n_halt   = r_halt;
        new_slot = '0;
        failed   = 1'b0;
        if (!r_halt) begin
            unique case (i_opcode)
                OP_TICK, OP_YIELD: begin
                    if (wrap) begin
                        n_presc = '0;
                        n_units = r_units + TIME_W'(1);
                        if (i_opcode == OP_TICK) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (r_delay[i] != '0) begin
                                    n_delay[i] = r_delay[i] - DELAY_W'(1);
                                end
                            end
                        end
                    end else begin
                        n_presc = presc_inc[TICK_W-1:0];
                    end
                    n_run = rot_slot;
                end
                OP_CREATE: begin
                    if (free_found) begin
                        n_live[free_slot] = 1'b1;
                        new_slot          = free_slot;
                    end else begin
                        failed = 1'b1;
                    end
                end
                OP_EXIT: begin
                    n_live = exit_live;
                    if (exit_live == '0) begin
                        n_halt = 1'b1;
                    end else begin
                        n_run = first_live;
                    end
                end
                OP_SET_DELAY: begin
                    n_delay[r_run] = i_delay_value;
                end
                default: begin
                end
            endcase
        end
    end

    // result beat from the updated state
    always_comb begin
        o_result.current_slot  = n_run;
        o_result.new_slot      = new_slot;
        o_result.create_failed = failed;
        o_result.live_mask     = n_live;
        o_result.time_now      = n_units;
        o_result.current_delay = n_delay[n_run];
        o_result.halted        = n_halt;
    end

    // state update on each accepted beat and each register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu   <= TICK_W'(1);
            r_live  <= SLOTS'(1);
            r_run   <= '0;
            r_presc <= '0;
            r_units <= '0;
            r_halt  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_delay[i] <= '0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_tpu <= i_cfg_data;
            end
            if (i_step) begin
                r_live  <= n_live;
                r_run   <= n_run;
                r_presc <= n_presc;
                r_units <= n_units;
                r_halt  <= n_halt;
                r_delay <= n_delay;
            end
        end
    end

    // running slot is live until the table empties
    `RRTS_ASSERT(a_run_live, i_clk, i_rst_n, !r_halt |-> r_live[r_run])
    // halt only with an empty table
    `RRTS_ASSERT(a_halt_empty, i_clk, i_rst_n, r_halt |-> (r_live == '0))
    // halt is sticky until reset
    `RRTS_ASSERT(a_halt_sticky, i_clk, i_rst_n, r_halt |=> r_halt)

endmodule

`default_nettype wire

// File: tb/tb_round_robin_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler_unit
// Self-checking bench for the four-slot round-robin thread scheduler.
// Events go in on the valid/ready event channel. A scoreboard class keeps its
// own copy of the slot table, the prescaler and the delay counters, predicts
// one result beat per accepted event and compares every returned beat field
// by field. Phases run at several unit lengths, zero and 255 among them. The
// run closes by emptying the slot table into the halted state and sending random opcodes there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler_unit;
    import rrts_pkg::*;

    // opcodes with no operation behind them
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_EVENTS = 110;

    // scheduler prediction and result checking
    class sched_scoreboard;
        logic [TICK_W-1:0]  unit_len;
        logic [SLOTS-1:0]   live;
        logic [SLOT_W-1:0]  run_slot;
        logic [TICK_W-1:0]  prescale;
        logic [TIME_W-1:0]  units;
        logic [DELAY_W-1:0] delay_left [SLOTS];
        logic               halt;
        t_result            pending_results [$];
        int                 errors;
        int                 n_checked;
        int                 n_create_fail;
        int                 n_halted_beats;

        function new();
            unit_len = TICK_W'(1);
            live = SLOTS'(1);
            run_slot = '0;
            prescale = '0;
            units = '0;
            for (int i = 0; i < SLOTS; i++) delay_left[i] = '0;
            halt = 1'b0;
            errors = 0;
            n_checked = 0;
            n_create_fail = 0;
            n_halted_beats = 0;
        endfunction

        // step the prescaler, report whether a time unit completed
        function bit unit_done();
            int unsigned len;
            int unsigned nxt;
            len = (unit_len == 0) ? 1 : unit_len;
            nxt = prescale + 1;
            if (nxt >= len) begin
                prescale = '0;
                units = units + 1'b1;
                return 1'b1;
            end
            prescale = TICK_W'(nxt);
            return 1'b0;
        endfunction

        // move to the next live slot after the running one
        function void rotate_next();
            int s;
            bit found;
            s = int'(run_slot);
            found = 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                s = (s + 1) % SLOTS;
                if (!found && live[s]) begin
                    run_slot = SLOT_W'(s);
                    found = 1'b1;
                end
            end
        endfunction

        // update the table for one accepted event and queue its result
        function void note_event(logic [OP_W-1:0] op, logic [DELAY_W-1:0] dv);
            t_result           want;
            logic [SLOT_W-1:0] claimed;
            logic              failed;
            bit                found;
            claimed = '0;
            failed = 1'b0;
            found = 1'b0;
            if (!halt) begin
                case (op)
                    OP_TICK: begin
                        if (unit_done()) begin
                            for (int i = 0; i < SLOTS; i++)
                                if (delay_left[i] != 0) delay_left[i] = delay_left[i] - 1'b1;
                        end
                        rotate_next();
                    end
                    OP_YIELD: begin
                        void'(unit_done());
                        rotate_next();
                    end
                    OP_CREATE: begin
                        failed = 1'b1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!found && !live[i]) begin
                                live[i] = 1'b1;
                                claimed = SLOT_W'(i);
                                failed = 1'b0;
                                found = 1'b1;
                            end
                        end
                        if (failed) n_create_fail++;
                    end
                    OP_EXIT: begin
                        live[run_slot] = 1'b0;
                        if (live == 0) begin
                            halt = 1'b1;
                        end else begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (!found && live[i]) begin
                                    run_slot = SLOT_W'(i);
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                    OP_SET_DELAY: begin
                        delay_left[run_slot] = dv;
                    end
                    default: begin
                    end
                endcase
            end
            want.current_slot = run_slot;
            want.new_slot = claimed;
            want.create_failed = failed;
            want.live_mask = live;
            want.time_now = units;
            want.current_delay = delay_left[run_slot];
            want.halted = halt;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        // compare one returned beat with the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with no event outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.halted === 1'b1) n_halted_beats++;
            compare_field("current_slot", 32'(want.current_slot), 32'(got.current_slot));
            compare_field("new_slot", 32'(want.new_slot), 32'(got.new_slot));
            compare_field("create_failed", 32'(want.create_failed),
                          32'(got.create_failed));
            compare_field("live_mask", 32'(want.live_mask), 32'(got.live_mask));
            compare_field("time_now", 32'(want.time_now), 32'(got.time_now));
            compare_field("current_delay", 32'(want.current_delay),
                          32'(got.current_delay));
            compare_field("halted", 32'(want.halted), 32'(got.halted));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [TICK_W-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_opcode = OP_TICK;
    logic [DELAY_W-1:0] i_delay_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [SLOT_W-1:0]  o_current_slot;
    logic [SLOT_W-1:0]  o_new_slot;
    logic               o_create_failed;
    logic [SLOTS-1:0]   o_live_mask;
    logic [TIME_W-1:0]  o_time_now;
    logic [DELAY_W-1:0] o_current_delay;
    logic               o_halted;

    sched_scoreboard sb = new();
    bit calm = 1'b0;
    int n_sent = 0;
    int cycles = 0;

    round_robin_thread_scheduler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_delay_value  (i_delay_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_current_slot (o_current_slot),
        .o_new_slot     (o_new_slot),
        .o_create_failed(o_create_failed),
        .o_live_mask    (o_live_mask),
        .o_time_now     (o_time_now),
        .o_current_delay(o_current_delay),
        .o_halted       (o_halted)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 17);
    end

    // result beat monitor
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.current_slot = o_current_slot;
            got.new_slot = o_new_slot;
            got.create_failed = o_create_failed;
            got.live_mask = o_live_mask;
            got.time_now = o_time_now;
            got.current_delay = o_current_delay;
            got.halted = o_halted;
            sb.check_result(got);
        end
    end

    // drive one event beat, with random gaps ahead of it
    task automatic send_event(input logic [OP_W-1:0] op, input logic [DELAY_W-1:0] dv);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_delay_value <= dv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_event(op, dv);
        n_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_unit_len(input logic [TICK_W-1:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.unit_len = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // weighted random events, kept away from emptying the table
    task automatic run_random(input int count);
        int r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30) op = OP_TICK;
            else if (r < 50) op = OP_YIELD;
            else if (r < 68) op = OP_CREATE;
            else if (r < 82) op = OP_EXIT;
            else if (r < 96) op = OP_SET_DELAY;
            else if (r < 97) op = OP_SPARE_A;
            else if (r < 98) op = OP_SPARE_B;
            else op = OP_SPARE_C;
            if (op == OP_EXIT && $countones(sb.live) == 1) op = OP_CREATE;
            send_event(op, DELAY_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [TICK_W-1:0] phase_len [8];
        phase_len = '{8'd0, 8'd255, 8'd2, 8'd1, 8'd5, 8'd1, 8'd255, 8'd3};
        phase_len[5] = TICK_W'($urandom_range(4, 254));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single live slot, delay extremes, full table, spare codes
        write_unit_len(8'd1);
        send_event(OP_TICK, 8'd0);
        send_event(OP_YIELD, 8'd255);
        send_event(OP_SET_DELAY, 8'd255);
        send_event(OP_TICK, 8'd0);
        send_event(OP_CREATE, 8'd0);
        send_event(OP_CREATE, 8'd0);
        send_event(OP_CREATE, 8'd0);
        send_event(OP_CREATE, 8'd255);
        send_event(OP_TICK, 8'd0);
        send_event(OP_SET_DELAY, 8'd0);
        send_event(OP_SET_DELAY, 8'hAA);
        send_event(OP_YIELD, 8'd0);
        send_event(OP_SET_DELAY, 8'h55);
        send_event(OP_TICK, 8'd0);
        send_event(OP_SPARE_A, 8'd255);
        send_event(OP_SPARE_B, 8'd0);
        send_event(OP_SPARE_C, 8'd255);
        send_event(OP_EXIT, 8'd0);
        send_event(OP_CREATE, 8'd0);
        send_event(OP_TICK, 8'd255);
        send_event(OP_SET_DELAY, 8'd1);
        wait_idle();

        // random phases, one unit length each; one phase with no idling
        for (int p = 0; p < 8; p++) begin
            calm = (p == 3);
            write_unit_len(phase_len[p]);
            run_random(PHASE_EVENTS);
            wait_idle();
        end
        calm = 1'b0;

        // empty the table, then random opcodes while halted
        while (!sb.halt) send_event(OP_EXIT, DELAY_W'($urandom_range(0, 255)));
        for (int n = 0; n < 12; n++)
            send_event(OP_W'($urandom_range(0, 7)), DELAY_W'($urandom_range(0, 255)));
        wait_idle();

        $display("covered %0d events and %0d result beats, %0d creates on a full table,",
                 n_sent, sb.n_checked, sb.n_create_fail);
        $display("unit lengths 0 to 255 and %0d beats in the halted state",
                 sb.n_halted_beats);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
